// ----- rtl/core/fpwl_pkg.sv -----
// Shared types, constants and helpers of the flow-pair water-level rate limiter.
`default_nettype none
package fpwl_pkg;

	localparam int PAIR_COUNT = 8;
	localparam int IDX_W = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;

	localparam logic [31:0] SIZE_INIT = 32'd544;
	localparam logic [17:0] RATE_SCALE = 18'd200000;
	localparam logic [15:0] UNITS_LIMIT = 16'd32768;
	localparam logic [15:0] PKTS_LIMIT = 16'd900;
	localparam logic [20:0] LEVEL_MIN = 21'd2;
	localparam logic [31:0] AVG_MIN = 32'd16;

	localparam logic [15:0] EPOCH_RESET = 16'd1000;
	localparam logic [20:0] MAXRATE_RESET = 21'd1048576;
	localparam logic [15:0] PROBE_RESET = 16'd1023;

	localparam logic [1:0] CFG_EPOCH = 2'd0;
	localparam logic [1:0] CFG_MAXRATE = 2'd1;
	localparam logic [1:0] CFG_PROBE = 2'd2;

	localparam logic [1:0] KIND_TX = 2'd1;
	localparam logic [1:0] KIND_RTT = 2'd2;

	typedef enum logic [1:0] {
		CMD_EVENT = 2'd0,
		CMD_BUDGET = 2'd1,
		CMD_BATCH = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic [31:0] flowtag;
		logic [1:0] event_kind;
		logic [31:0] now_us;
		logic [15:0] sent_units;
		logic [15:0] sent_packets;
		logic [20:0] budget;
		logic [31:0] remote_rate;
		logic [31:0] remote_limit;
		logic [2:0] pair_index;
	} in_t;

	typedef struct packed {
		logic [20:0] rate;
		logic rtt_request;
		logic [31:0] q_flowtag;
		logic [20:0] q_budget;
		logic [20:0] q_level;
		logic [31:0] q_remote_rate;
		logic [31:0] q_measured_rate;
		logic [31:0] q_hits;
		logic [31:0] q_epochs;
		logic [31:0] q_remote_limit;
		logic [31:0] last_unknown;
	} out_t;

	typedef struct packed {
		logic [20:0] budget;
		logic [20:0] level;
		logic [31:0] epoch_start;
		logic [31:0] avg;
		logic [31:0] accum;
		logic [31:0] smoothed;
		logic [31:0] last_remote;
		logic [31:0] rrate;
		logic [31:0] rlimit;
		logic [31:0] hits;
		logic [31:0] epochs;
	} rec_t;

	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] addr;
		rec_t data;
	} mem_wr_t;

	// Reduces a query index into the table range by repeated subtraction.
	function automatic logic [IDX_W-1:0] pair_of(input logic [2:0] p);
		logic [3:0] v;
		v = {1'b0, p};
		for (int k = 0; k < 8; k++) begin
			if (32'(v) >= 32'(PAIR_COUNT)) begin
				v = 4'(32'(v) - 32'(PAIR_COUNT));
			end
		end
		return IDX_W'(v);
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/flow_pair_water_level_rate_limiter.sv -----
// Top level: key lookup, event sequencer and control step of the rate limiter.
//
//  channel | signals                        | role
//  in      | in_valid, in_ready, in_data    | command word in
//  out     | out_valid, out_ready, out_data | result word out
//  cfg     | cfg_we, cfg_addr, cfg_wdata    | register writes
//
// One word is processed at a time; ready is high only when the sequencer is idle.
// Queries and applied set commands read one entry; unknown flows and ignored set
// commands read none. A known flow event makes up to three passes through the shared
// divider (size sample, epoch rate, control step). A stalled result word holds the
// sequencer in its last state. A finished result waits in the output register while
// the next word is taken.
// Reset is asynchronous; no clearing pass is needed.
`default_nettype none
module flow_pair_water_level_rate_limiter (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire fpwl_pkg::in_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output fpwl_pkg::out_t out_data,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_addr,
	input wire logic [20:0] cfg_wdata
);
	typedef enum logic [3:0] {
		S_IDLE, S_LOOK, S_RD, S_SGO, S_SWAIT, S_MUL1, S_ACC, S_EPOCH,
		S_RGO, S_RWAIT, S_CMUL, S_CGO, S_CWAIT, S_WB, S_OUT
	} state_t;

	state_t state_q;
	fpwl_pkg::in_t in_q;
	fpwl_pkg::rec_t rec_q;
	fpwl_pkg::out_t res_q;
	fpwl_pkg::out_t out_q;
	logic out_valid_q;
	logic [31:0] key_q [fpwl_pkg::PAIR_COUNT];
	logic [15:0] epoch_len_q;
	logic [20:0] max_rate_q;
	logic [15:0] probe_mask_q;
	logic [31:0] unknown_q;
	logic [31:0] miss_q;
	logic hit_q;
	logic [fpwl_pkg::IDX_W-1:0] idx_q;
	logic [63:0] prod_q;
	logic [31:0] old_q;
	logic [31:0] b32_q;
	logic [31:0] rs_q;
	logic neg_q;
	logic errnz_q;
	logic want_q;

	logic hit, fre;
	logic set_skip;
	logic [fpwl_pkg::IDX_W-1:0] hidx, fidx;
	fpwl_pkg::mem_wr_t wr;
	logic rd_en;
	logic [fpwl_pkg::IDX_W-1:0] rd_addr;
	fpwl_pkg::rec_t rd_data;
	fpwl_pkg::rec_t set_rec;
	fpwl_pkg::rec_t ev_rec;
	fpwl_pkg::out_t res_fin;
	logic div_go, div_done;
	logic [63:0] div_a, div_b, div_q;

	logic [31:0] sample, avg_new;
	logic [31:0] elapsed, dt;
	logic [31:0] rs;
	logic ctrl;
	logic signed [33:0] err;
	logic [32:0] err_mag;
	logic [63:0] adj;
	logic [18:0] lim;
	logic signed [23:0] nl, fl;

	fpwl_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go), .dividend(div_a),
		.divisor(div_b), .done(div_done), .quotient(div_q)
	);

	fpwl_pair_mem u_mem (
		.clk(clk), .arst_n(arst_n), .wr(wr), .rd_en(rd_en),
		.rd_addr(rd_addr), .rd_data(rd_data)
	);

	always_comb begin
		hit = 1'b0;
		fre = 1'b0;
		hidx = '0;
		fidx = '0;
		for (int i = 0; i < fpwl_pkg::PAIR_COUNT; i++) begin
			if (!hit && key_q[i] == in_q.flowtag) begin
				hit = 1'b1;
				hidx = fpwl_pkg::IDX_W'(i);
			end
			if (!fre && key_q[i] == 32'd0) begin
				fre = 1'b1;
				fidx = fpwl_pkg::IDX_W'(i);
			end
		end
		hit = hit && (in_q.flowtag != 32'd0);
	end

	// A set command reads no entry when it is ignored or only deletes a key.
	assign set_skip = in_q.flowtag == 32'd0 || in_q.budget == 21'd0 || (!hit && !fre);

	always_comb begin
		rd_en = 1'b0;
		rd_addr = hidx;
		if (state_q == S_LOOK) begin
			case (in_q.cmd)
				fpwl_pkg::CMD_QUERY: begin
					rd_en = 1'b1;
					rd_addr = fpwl_pkg::pair_of(in_q.pair_index);
				end
				fpwl_pkg::CMD_EVENT: rd_en = hit;
				default: begin
					rd_en = !set_skip;
					rd_addr = hit ? hidx : fidx;
				end
			endcase
		end
	end

	// New record for a set command, built from the entry as read.
	always_comb begin
		set_rec = rd_data;
		if (hit_q) begin
			if (in_q.cmd == fpwl_pkg::CMD_BATCH) begin
				if (rd_data.budget != in_q.budget) begin
					set_rec.budget = in_q.budget;
					set_rec.level = in_q.budget;
				end
				set_rec.rrate = in_q.remote_rate;
			end else begin
				set_rec.budget = in_q.budget;
				set_rec.level = in_q.budget;
			end
		end else begin
			set_rec.budget = in_q.budget;
			set_rec.level = in_q.budget;
			if (in_q.cmd == fpwl_pkg::CMD_BATCH) begin
				set_rec.rrate = in_q.remote_rate;
			end else begin
				set_rec.avg = fpwl_pkg::SIZE_INIT;
			end
			set_rec.accum = '0;
			set_rec.epoch_start = '0;
		end
	end

	// Entry as read, with the receiver report of an RTT response stored.
	always_comb begin
		ev_rec = rd_data;
		if (in_q.event_kind == fpwl_pkg::KIND_RTT) begin
			ev_rec.rrate = in_q.remote_rate;
			ev_rec.rlimit = in_q.remote_limit;
		end
	end

	always_comb begin
		res_fin = res_q;
		res_fin.last_unknown = unknown_q;
	end

	always_comb begin
		wr.en = 1'b0;
		wr.addr = idx_q;
		wr.data = rec_q;
		if (state_q == S_WB) begin
			wr.en = 1'b1;
		end else if (state_q == S_RD &&
				(in_q.cmd == fpwl_pkg::CMD_BUDGET || in_q.cmd == fpwl_pkg::CMD_BATCH)) begin
			wr.en = 1'b1;
			wr.data = set_rec;
		end
	end

	always_comb begin
		div_go = 1'b0;
		div_a = '0;
		div_b = '0;
		case (state_q)
			S_SGO: begin
				div_go = 1'b1;
				div_a = {44'd0, in_q.sent_units, 4'd0};
				div_b = {48'd0, in_q.sent_packets};
			end
			S_RGO: begin
				div_go = 1'b1;
				div_a = {4'd0, b32_q, 28'd0};
				div_b = prod_q;
			end
			S_CGO: begin
				div_go = 1'b1;
				div_a = prod_q;
				div_b = {40'd0, rec_q.budget, 3'd0};
			end
			default: ;
		endcase
	end

	// Size sample folded into the running average (1/16 weight).
	always_comb begin
		sample = div_q[31:0];
		if (sample >= rec_q.avg) begin
			avg_new = rec_q.avg + ((sample - rec_q.avg) >> 4);
		end else begin
			avg_new = rec_q.avg - 32'(({1'b0, rec_q.avg} - {1'b0, sample} + 33'd15) >> 4);
		end
		if (avg_new < fpwl_pkg::AVG_MIN) begin
			avg_new = fpwl_pkg::AVG_MIN;
		end
		elapsed = in_q.now_us - rec_q.epoch_start;
		dt = (elapsed == 32'd0) ? 32'd1 : elapsed;
	end

	// Measured rate: remote report if any, else byte rate smoothed by 1/4.
	always_comb begin
		ctrl = 1'b1;
		if (rec_q.rrate != 32'd0) begin
			rs = rec_q.rrate;
			ctrl = rec_q.rrate != rec_q.last_remote;
		end else if (div_q >= {32'd0, rec_q.smoothed}) begin
			rs = rec_q.smoothed + 32'((div_q - {32'd0, rec_q.smoothed}) >> 2);
		end else begin
			rs = rec_q.smoothed -
				32'(({1'b0, rec_q.smoothed} - {1'b0, div_q[31:0]} + 33'd3) >> 2);
		end
	end

	always_comb begin
		err = $signed({13'd0, rec_q.budget}) - $signed({2'd0, rs_q});
		err_mag = (err < 0) ? 33'(-err) : 33'(err);
		adj = div_q;
		if (adj == 64'd0 && errnz_q) begin
			adj = 64'd1;
		end
		lim = {1'b0, rec_q.level[20:3]} + 19'd1;
		if (adj > {45'd0, lim}) begin
			adj = {45'd0, lim};
		end
		if (neg_q) begin
			nl = $signed({3'd0, rec_q.level}) - $signed({5'd0, adj[18:0]});
		end else begin
			nl = $signed({3'd0, rec_q.level}) + $signed({5'd0, adj[18:0]});
		end
		fl = $signed({3'd0, (rec_q.budget >> 7) + fpwl_pkg::LEVEL_MIN});
		if (nl < fl) begin
			nl = fl;
		end
		if (nl > $signed({3'd0, rec_q.budget})) begin
			nl = $signed({3'd0, rec_q.budget});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			in_q <= '0;
			rec_q <= '0;
			res_q <= '0;
			out_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < fpwl_pkg::PAIR_COUNT; i++) begin
				key_q[i] <= '0;
			end
			epoch_len_q <= fpwl_pkg::EPOCH_RESET;
			max_rate_q <= fpwl_pkg::MAXRATE_RESET;
			probe_mask_q <= fpwl_pkg::PROBE_RESET;
			unknown_q <= '0;
			miss_q <= '0;
			hit_q <= 1'b0;
			idx_q <= '0;
			prod_q <= '0;
			old_q <= '0;
			b32_q <= '0;
			rs_q <= '0;
			neg_q <= 1'b0;
			errnz_q <= 1'b0;
			want_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					fpwl_pkg::CFG_EPOCH: epoch_len_q <= cfg_wdata[15:0];
					fpwl_pkg::CFG_MAXRATE: max_rate_q <= cfg_wdata;
					fpwl_pkg::CFG_PROBE: probe_mask_q <= cfg_wdata[15:0];
					default: ;
				endcase
			end
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						in_q <= in_data;
						res_q <= '0;
						want_q <= 1'b0;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					hit_q <= hit;
					idx_q <= rd_addr;
					state_q <= rd_en ? S_RD : S_OUT;
					case (in_q.cmd)
						fpwl_pkg::CMD_QUERY: ;
						fpwl_pkg::CMD_EVENT: begin
							if (!hit) begin
								unknown_q <= in_q.flowtag;
								miss_q <= miss_q + 32'd1;
								res_q.rate <= max_rate_q;
								res_q.rtt_request <=
									((miss_q + 32'd1) & {16'd0, probe_mask_q}) == 32'd0;
							end
						end
						default: begin
							if (hit && in_q.budget == 21'd0) begin
								key_q[hidx] <= '0;
							end
						end
					endcase
				end
				S_RD: begin
					case (in_q.cmd)
						fpwl_pkg::CMD_QUERY: begin
							res_q.q_flowtag <= key_q[idx_q];
							res_q.q_budget <= rd_data.budget;
							res_q.q_level <= rd_data.level;
							res_q.q_remote_rate <= rd_data.rrate;
							res_q.q_measured_rate <= rd_data.smoothed;
							res_q.q_hits <= rd_data.hits;
							res_q.q_epochs <= rd_data.epochs;
							res_q.q_remote_limit <= rd_data.rlimit;
							state_q <= S_OUT;
						end
						fpwl_pkg::CMD_EVENT: begin
							rec_q <= ev_rec;
							if (in_q.event_kind == fpwl_pkg::KIND_TX &&
									in_q.sent_packets != 16'd0) begin
								if (in_q.sent_units < fpwl_pkg::UNITS_LIMIT &&
										in_q.sent_packets < fpwl_pkg::PKTS_LIMIT) begin
									state_q <= S_SGO;
								end else begin
									state_q <= S_MUL1;
								end
							end else begin
								state_q <= S_EPOCH;
							end
						end
						default: begin
							if (!hit_q) begin
								key_q[idx_q] <= in_q.flowtag;
							end
							state_q <= S_OUT;
						end
					endcase
				end
				S_SGO: state_q <= S_SWAIT;
				S_SWAIT: begin
					if (div_done) begin
						rec_q.avg <= avg_new;
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					prod_q <= {16'd0, 48'(in_q.sent_packets) * 48'(rec_q.avg)};
					state_q <= S_ACC;
				end
				S_ACC: begin
					rec_q.accum <= rec_q.accum + prod_q[35:4];
					state_q <= S_EPOCH;
				end
				S_EPOCH: begin
					rec_q.hits <= rec_q.hits + 32'd1;
					if (elapsed >= {16'd0, epoch_len_q}) begin
						prod_q <= {14'd0, 50'(dt) * 50'(fpwl_pkg::RATE_SCALE)};
						old_q <= rec_q.epoch_start;
						b32_q <= rec_q.accum;
						rec_q.epoch_start <= in_q.now_us;
						rec_q.accum <= '0;
						want_q <= 1'b1;
						state_q <= S_RGO;
					end else begin
						state_q <= S_WB;
					end
				end
				S_RGO: state_q <= S_RWAIT;
				S_RWAIT: begin
					if (div_done) begin
						rec_q.smoothed <= rs;
						rec_q.epochs <= rec_q.epochs + 32'd1;
						if (rec_q.rrate != 32'd0) begin
							rec_q.last_remote <= rec_q.rrate;
						end
						rs_q <= rs;
						if (ctrl && old_q != 32'd0 && rec_q.budget != 21'd0) begin
							state_q <= S_CMUL;
						end else begin
							state_q <= S_WB;
						end
					end
				end
				S_CMUL: begin
					prod_q <= {10'd0, 54'(rec_q.level) * 54'(err_mag)};
					neg_q <= err < 0;
					errnz_q <= err != 0;
					state_q <= S_CGO;
				end
				S_CGO: state_q <= S_CWAIT;
				S_CWAIT: begin
					if (div_done) begin
						rec_q.level <= nl[20:0];
						state_q <= S_WB;
					end
				end
				S_WB: begin
					res_q.rate <= (max_rate_q < rec_q.level) ? max_rate_q : rec_q.level;
					res_q.rtt_request <= want_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_q <= res_fin;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
endmodule
`default_nettype wire

// ----- rtl/core/fpwl_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module fpwl_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [63:0] dividend,
	input wire logic [63:0] divisor,
	output logic done,
	output logic [63:0] quotient
);
	logic [63:0] quo_q;
	logic [63:0] rem_q;
	logic [63:0] div_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [64:0] trial;
	logic take;

	assign trial = {rem_q, quo_q[63]};
	assign take = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q <= '0;
			rem_q <= '0;
			div_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q <= dividend;
				rem_q <= '0;
				div_q <= divisor;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= take ? 64'(trial - {1'b0, div_q}) : trial[63:0];
				quo_q <= {quo_q[62:0], take};
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// ----- rtl/core/fpwl_pair_mem.sv -----
// Pair record memory with registered read and per-entry valid bits.
`default_nettype none
module fpwl_pair_mem (
	input wire logic clk,
	input wire logic arst_n,
	input wire fpwl_pkg::mem_wr_t wr,
	input wire logic rd_en,
	input wire logic [fpwl_pkg::IDX_W-1:0] rd_addr,
	output fpwl_pkg::rec_t rd_data
);
	fpwl_pkg::rec_t mem [fpwl_pkg::PAIR_COUNT];
	fpwl_pkg::rec_t rd_q;
	logic [fpwl_pkg::PAIR_COUNT-1:0] valid_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// An entry never written reads as zero, as after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;
endmodule
`default_nettype wire

// ----- rtl/core/fpwl_chk.sv -----
// Port-level checker for the rate limiter, bound to the top level.
`default_nettype none
module fpwl_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire fpwl_pkg::in_t in_data,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire fpwl_pkg::out_t out_data
);
	// A stalled result word keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// Only one word is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word accepted while busy");

	// A rate answer and query contents never come from the same command.
	a_rate_vs_query: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.rate != 21'd0 || out_data.rtt_request) |->
			out_data.q_flowtag == 32'd0 && out_data.q_budget == 21'd0 &&
			out_data.q_hits == 32'd0)
		else $error("flow answer mixed with query contents");

	// A query returns no rate.
	a_query_no_rate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.q_hits != 32'd0 |->
			out_data.rate == 21'd0 && !out_data.rtt_request)
		else $error("query carried a rate");
endmodule

bind flow_pair_water_level_rate_limiter fpwl_chk u_fpwl_chk (.*);
`default_nettype wire
